// ===== hw/rtl/nncf_pkg.sv =====
// shared types, constants and ratio table for the nearest note cents finder
`default_nettype none
package nncf_pkg;

    localparam int NOTES          = 12;
    localparam int FREQ_W         = 19;
    localparam int CENTS_W        = 12;
    localparam int DEF_OCTAVES    = 6;
    localparam int DEF_FRAC_BITS  = 8;
    localparam int RATIO_W        = 17;
    localparam int PROD_W         = FREQ_W + RATIO_W;
    localparam logic [FREQ_W-1:0] RESET_A4 = 19'd112640;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 19'd524287;

    // twice the Q7.4 cents per semitone scale
    localparam logic [11:0] CENT_SCALE2 = 12'd3200;
    localparam logic [CENTS_W-1:0] CENT_MAX = 12'h7FF;
    localparam logic [CENTS_W-1:0] CENT_MIN = 12'h800;
    localparam int TUNE_LIMIT = 64;

    // per-item note labels carried to the result
    typedef struct packed {
        logic [3:0] note;
        logic [2:0] octave;
        logic [3:0] lower_note;
        logic       lower_valid;
        logic [3:0] higher_note;
        logic       higher_valid;
        logic       out_of_range;
    } tag_t;

    // running search state of one request
    typedef struct packed {
        logic [FREQ_W-1:0] x;
        logic [FREQ_W-1:0] best;
        logic [FREQ_W-1:0] fn;
        logic [FREQ_W-1:0] fl;
        logic [FREQ_W-1:0] fh;
        tag_t              tag;
    } scan_t;

    // 2^((n-9)/12) in unsigned Q1.16
    function automatic logic [RATIO_W-1:0] semi_ratio(input logic [3:0] n);
        logic [RATIO_W-1:0] r;
        unique case (n)
            4'd0:    r = 17'd38968;
            4'd1:    r = 17'd41285;
            4'd2:    r = 17'd43740;
            4'd3:    r = 17'd46341;
            4'd4:    r = 17'd49097;
            4'd5:    r = 17'd52016;
            4'd6:    r = 17'd55109;
            4'd7:    r = 17'd58386;
            4'd8:    r = 17'd61858;
            4'd9:    r = 17'd65536;
            4'd10:   r = 17'd69433;
            4'd11:   r = 17'd73562;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nearest_note_cents_finder_core.sv =====
// top level: reference register, note table build, search and cents pipelines
// throughput: one request per cycle outside a table rebuild; one stage per table entry plus
//   one stage per quotient bit; the whole pipeline holds while the result waits
// reset and reference writes rebuild the note table with one multiply per note;
//   s_ready is low while the rebuild runs
// synchronous active-low reset clears valid bits, restores the reference and starts the build sequencer
`default_nettype none
module nearest_note_cents_finder_core #(
    parameter int OCTAVES        = nncf_pkg::DEF_OCTAVES,
    parameter int FREQ_FRAC_BITS = nncf_pkg::DEF_FRAC_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [nncf_pkg::FREQ_W-1:0]  cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [nncf_pkg::FREQ_W-1:0]  s_measured_freq,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [3:0]                        m_nearest_note,
    output logic [2:0]                        m_nearest_octave,
    output logic [3:0]                        m_lower_note,
    output logic                              m_lower_valid,
    output logic [3:0]                        m_higher_note,
    output logic                              m_higher_valid,
    output logic signed [nncf_pkg::CENTS_W-1:0] m_cents_offset,
    output logic                              m_in_tune,
    output logic                              m_out_of_range
);
    import nncf_pkg::*;

    localparam int TBL = NOTES * OCTAVES;
    localparam logic [31:0] FREQ_LOW   = 32'd10 << FREQ_FRAC_BITS;
    localparam logic [31:0] FREQ_HIGH  = 32'd1500 << FREQ_FRAC_BITS;
    localparam logic [31:0] FREQ_SUBST = ((32'd1 << FREQ_FRAC_BITS) + 32'd50) / 32'd100;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BUILD = 2'b10
    } bld_state_t;

    bld_state_t          state_reg, state_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                wr_reg, wr_next;
    logic [3:0]          note_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [FREQ_W-1:0]   a4_reg;
    logic [FREQ_W-1:0]   note_tbl_reg [TBL];
    logic [FREQ_W-1:0]   ent [OCTAVES];
    logic                en;

    // reference register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a4_reg <= RESET_A4;
        end else if (cfg_wr_en) begin
            a4_reg <= cfg_wr_data;
        end
    end

    // build sequencer: one note product per cycle
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        wr_next    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
            end
            ST_BUILD: begin
                if (cnt_reg < 4'(NOTES)) begin
                    wr_next  = 1'b1;
                    cnt_next = cnt_reg + 4'd1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_BUILD;
        endcase
        if (cfg_wr_en) begin
            state_next = ST_BUILD;
            cnt_next   = '0;
            wr_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BUILD;
            cnt_reg   <= '0;
            wr_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wr_reg    <= wr_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a4_reg) * PROD_W'(semi_ratio(cnt_reg));
        note_reg <= cnt_reg;
    end

    // octave entries: rounded shift and saturation
    always_comb begin
        for (int o = 0; o < OCTAVES; o++) begin
            logic [PROD_W:0] v;
            v = ((PROD_W+1)'(prod_reg) + ((PROD_W+1)'(1) << (19 - o))) >> (20 - o);
            ent[o] = (v > (PROD_W+1)'(FREQ_MAX)) ? FREQ_MAX : v[FREQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        for (int n = 0; n < NOTES; n++) begin
            for (int o = 0; o < OCTAVES; o++) begin
                if (wr_reg && note_reg == 4'(n)) begin
                    note_tbl_reg[n*OCTAVES+o] <= ent[o];
                end
            end
        end
    end

    // request entry with range check and substitution
    scan_t               in_next, in_reg;
    logic                in_vld_reg;
    logic                oor;
    logic                scan_vld;
    scan_t               scan_item;
    tag_t                out_tag;
    logic [CENTS_W-1:0]  out_cents;

    assign en      = !m_valid || m_ready;
    assign s_ready = en && (state_reg == ST_IDLE);

    always_comb begin
        oor     = (32'(s_measured_freq) < FREQ_LOW) || (32'(s_measured_freq) > FREQ_HIGH);
        in_next = '0;
        in_next.x = oor ? FREQ_W'(FREQ_SUBST) : s_measured_freq;
        in_next.tag.out_of_range = oor;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= in_next;
        end
    end

    nncf_scan #(
        .OCTAVES(OCTAVES)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en_i       (en),
        .in_valid_i (in_vld_reg),
        .in_item_i  (in_reg),
        .tbl_i      (note_tbl_reg),
        .out_valid_o(scan_vld),
        .out_item_o (scan_item)
    );

    nncf_cents u_cents (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en_i         (en),
        .in_valid_i   (scan_vld),
        .in_item_i    (scan_item),
        .out_valid_o  (m_valid),
        .out_tag_o    (out_tag),
        .out_cents_o  (out_cents),
        .out_in_tune_o(m_in_tune)
    );

    assign m_nearest_note   = out_tag.note;
    assign m_nearest_octave = out_tag.octave;
    assign m_lower_note     = out_tag.lower_note;
    assign m_lower_valid    = out_tag.lower_valid;
    assign m_higher_note    = out_tag.higher_note;
    assign m_higher_valid   = out_tag.higher_valid;
    assign m_out_of_range   = out_tag.out_of_range;
    assign m_cents_offset   = $signed(out_cents);

    // no request taken while the table is rebuilt
    a_no_accept_in_build: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUILD) |-> !s_ready)
        else $error("request accepted during table build");

    // missing lower neighbour reports the nearest note
    a_lower_fallback: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_lower_valid) |-> (m_lower_note == m_nearest_note))
        else $error("lower note differs without lower neighbour");

    // tune flag agrees with the cents value
    a_tune_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_in_tune) |-> (m_cents_offset >= -12'sd64 && m_cents_offset <= 12'sd64))
        else $error("in tune flag set outside tune window");

    // a result held for the consumer does not move
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_cents_offset) && $stable(m_nearest_note))
        else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== hw/rtl/nncf_scan.sv =====
// systolic nearest-entry search, one table entry per pipeline stage
`default_nettype none
module nncf_scan #(
    parameter int OCTAVES = nncf_pkg::DEF_OCTAVES
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en_i,
    input  wire logic                       in_valid_i,
    input  wire nncf_pkg::scan_t            in_item_i,
    input  wire logic [nncf_pkg::FREQ_W-1:0] tbl_i [nncf_pkg::NOTES*OCTAVES],
    output logic                            out_valid_o,
    output nncf_pkg::scan_t                 out_item_o
);
    import nncf_pkg::*;

    localparam int TBL = NOTES * OCTAVES;

    scan_t st_reg   [TBL];
    logic  vld_reg  [TBL];
    scan_t cell_in  [TBL];
    logic  vld_in   [TBL];

    assign cell_in[0] = in_item_i;
    assign vld_in[0]  = in_valid_i;

    for (genvar k = 0; k < TBL; k++) begin : g_cell
        localparam int N_I = k / OCTAVES;
        localparam int O_I = k % OCTAVES;
        localparam bit LV  = (N_I > 0) || (O_I > 0);
        localparam bit HV  = (N_I < NOTES - 1) || (O_I + 1 < OCTAVES);
        localparam int LN  = (N_I > 0) ? N_I - 1 : (O_I > 0 ? NOTES - 1 : N_I);
        localparam int LO  = (N_I > 0) ? O_I : (O_I > 0 ? O_I - 1 : O_I);
        localparam int HN  = (N_I < NOTES - 1) ? N_I + 1 : (HV ? 0 : N_I);
        localparam int HO  = (N_I < NOTES - 1) ? O_I : (HV ? O_I + 1 : O_I);
        localparam int LIDX = LN * OCTAVES + LO;
        localparam int HIDX = HN * OCTAVES + HO;

        logic [FREQ_W-1:0] diff;
        scan_t             st_next;

        if (k > 0) begin : g_link
            assign cell_in[k] = st_reg[k-1];
            assign vld_in[k]  = vld_reg[k-1];
        end

        // compare this entry against the running best
        always_comb begin
            st_next = cell_in[k];
            diff = (tbl_i[k] > cell_in[k].x) ? tbl_i[k] - cell_in[k].x
                                              : cell_in[k].x - tbl_i[k];
            if ((k == 0) || (diff < cell_in[k].best)) begin
                st_next.best             = diff;
                st_next.fn               = tbl_i[k];
                st_next.fl               = LV ? tbl_i[LIDX] : '0;
                st_next.fh               = HV ? tbl_i[HIDX] : '0;
                st_next.tag.note         = 4'(N_I);
                st_next.tag.octave       = 3'(O_I);
                st_next.tag.lower_note   = 4'(LN);
                st_next.tag.lower_valid  = LV;
                st_next.tag.higher_note  = 4'(HN);
                st_next.tag.higher_valid = HV;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en_i) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en_i) begin
                st_reg[k] <= st_next;
            end
        end
    end

    assign out_valid_o = vld_reg[TBL-1];
    assign out_item_o  = st_reg[TBL-1];

endmodule
`default_nettype wire

// ===== hw/rtl/nncf_cents.sv =====
// cents computation: spacing select, scaling and pipelined restoring divide
`default_nettype none
module nncf_cents (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en_i,
    input  wire logic                         in_valid_i,
    input  wire nncf_pkg::scan_t              in_item_i,
    output logic                              out_valid_o,
    output nncf_pkg::tag_t                    out_tag_o,
    output logic [nncf_pkg::CENTS_W-1:0]      out_cents_o,
    output logic                              out_in_tune_o
);
    import nncf_pkg::*;

    localparam int QB    = 12;
    localparam int NUM_W = 32;
    localparam int DV_W  = FREQ_W + 2;
    localparam int CMP_W = DV_W + QB;

    typedef struct packed {
        tag_t              tag;
        logic              zero_d;
        logic              den_zero;
        logic              neg;
        logic [FREQ_W-1:0] d;
        logic [FREQ_W:0]   ad;
    } prep_t;

    typedef struct packed {
        tag_t             tag;
        logic             zero_d;
        logic             den_zero;
        logic             neg;
        logic             ovf;
        logic [NUM_W-1:0] rem;
        logic [DV_W-1:0]  dv;
        logic [QB-1:0]    q;
    } div_t;

    // stage 1: side, distance and spacing
    prep_t             p1_next, p1_reg;
    logic              p1_vld_reg;
    logic              hi;
    logic [FREQ_W:0]   den;

    always_comb begin
        hi  = in_item_i.x > in_item_i.fn;
        den = hi ? {1'b0, in_item_i.fh} - {1'b0, in_item_i.fn}
                 : {1'b0, in_item_i.fl} - {1'b0, in_item_i.fn};
        p1_next.tag      = in_item_i.tag;
        p1_next.d        = hi ? in_item_i.x - in_item_i.fn : in_item_i.fn - in_item_i.x;
        p1_next.zero_d   = (in_item_i.x == in_item_i.fn);
        p1_next.den_zero = (den == '0);
        p1_next.neg      = den[FREQ_W];
        p1_next.ad       = den[FREQ_W] ? (FREQ_W+1)'(0) - den : den;
    end

    // stage 2: scaled numerator and doubled divisor
    div_t d0_next;
    div_t dv_reg  [QB+2];
    logic dvld_reg [QB+2];
    div_t dv_next [QB+2];

    always_comb begin
        d0_next.tag      = p1_reg.tag;
        d0_next.zero_d   = p1_reg.zero_d;
        d0_next.den_zero = p1_reg.den_zero;
        d0_next.neg      = p1_reg.neg;
        d0_next.ovf      = 1'b0;
        d0_next.rem      = NUM_W'(p1_reg.d) * NUM_W'(CENT_SCALE2) + NUM_W'(p1_reg.ad);
        d0_next.dv       = {p1_reg.ad, 1'b0};
        d0_next.q        = '0;
    end

    // stage 3: quotient overflow check
    always_comb begin
        dv_next[0] = d0_next;
        dv_next[1] = dv_reg[0];
        dv_next[1].ovf = (CMP_W+1)'(dv_reg[0].rem)
                      >= (CMP_W+1)'({dv_reg[0].dv, {QB{1'b0}}});
    end

    // one quotient bit per stage
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int BI = QB - 1 - j;
        logic [CMP_W:0] sh;
        always_comb begin
            dv_next[j+2] = dv_reg[j+1];
            sh = (CMP_W+1)'(dv_reg[j+1].dv) << BI;
            if ((CMP_W+1)'(dv_reg[j+1].rem) >= sh) begin
                dv_next[j+2].rem   = dv_reg[j+1].rem - NUM_W'(sh);
                dv_next[j+2].q[BI] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            p1_reg <= p1_next;
            for (int i = 0; i < QB + 2; i++) begin
                dv_reg[i] <= dv_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            for (int i = 0; i < QB + 2; i++) begin
                dvld_reg[i] <= 1'b0;
            end
        end else if (en_i) begin
            p1_vld_reg  <= in_valid_i;
            dvld_reg[0] <= p1_vld_reg;
            for (int i = 1; i < QB + 2; i++) begin
                dvld_reg[i] <= dvld_reg[i-1];
            end
        end
    end

    // sign, saturation and tune flag into the output register
    div_t                fin;
    logic [CENTS_W-1:0]  cents_next;
    logic                tune_next;
    logic [CENTS_W-1:0]  cents_reg;
    logic                tune_reg;
    tag_t                tag_reg;
    logic                out_vld_reg;

    assign fin = dv_reg[QB+1];

    always_comb begin
        priority if (fin.zero_d) begin
            cents_next = '0;
        end else if (fin.den_zero) begin
            cents_next = CENT_MAX;
        end else if (!fin.neg) begin
            cents_next = (fin.ovf || fin.q > CENT_MAX) ? CENT_MAX : fin.q;
        end else begin
            cents_next = (fin.ovf || fin.q > CENT_MIN) ? CENT_MIN
                                                     : CENTS_W'(13'd0 - {1'b0, fin.q});
        end
        tune_next = ($signed(cents_next) >= -CENTS_W'(TUNE_LIMIT))
                 && ($signed(cents_next) <= $signed(CENTS_W'(TUNE_LIMIT)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en_i) begin
            out_vld_reg <= dvld_reg[QB+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            cents_reg <= cents_next;
            tune_reg  <= tune_next;
            tag_reg   <= fin.tag;
        end
    end

    assign out_valid_o   = out_vld_reg;
    assign out_tag_o     = tag_reg;
    assign out_cents_o   = cents_reg;
    assign out_in_tune_o = tune_reg;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the nearest note cents finder core
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import nncf_pkg::*;

    localparam int OCT = DEF_OCTAVES;
    localparam int LATENCY = 1 + NOTES * OCT + 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [FREQ_W-1:0] FREQ_LOW = 19'd2560;
    localparam logic [FREQ_W-1:0] FREQ_HIGH = 19'd384000;
    localparam logic [FREQ_W-1:0] FREQ_SUBST = 19'd3;

    typedef struct packed {
        logic [3:0]         note;
        logic [2:0]         octave;
        logic [3:0]         lower_note;
        logic               lower_valid;
        logic [3:0]         higher_note;
        logic               higher_valid;
        logic [CENTS_W-1:0] cents;
        logic               in_tune;
        logic               out_of_range;
    } note_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [FREQ_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [FREQ_W-1:0] s_measured_freq = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3:0] m_nearest_note;
    logic [2:0] m_nearest_octave;
    logic [3:0] m_lower_note;
    logic m_lower_valid;
    logic [3:0] m_higher_note;
    logic m_higher_valid;
    logic signed [CENTS_W-1:0] m_cents_offset;
    logic m_in_tune;
    logic m_out_of_range;

    logic [FREQ_W-1:0] freq_queue[$];
    note_result_t expected_notes[$];
    logic [FREQ_W-1:0] pitch_table[NOTES][OCT];
    int errors = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_phase = 0;

    always #5 aclk = ~aclk;

    nearest_note_cents_finder_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_measured_freq(s_measured_freq),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_nearest_note(m_nearest_note), .m_nearest_octave(m_nearest_octave),
        .m_lower_note(m_lower_note), .m_lower_valid(m_lower_valid),
        .m_higher_note(m_higher_note), .m_higher_valid(m_higher_valid),
        .m_cents_offset(m_cents_offset), .m_in_tune(m_in_tune),
        .m_out_of_range(m_out_of_range)
    );

    function automatic logic [16:0] ratio_of(input int n);
        case (n)
            0: return 17'd38968;   1: return 17'd41285;   2: return 17'd43740;
            3: return 17'd46341;   4: return 17'd49097;   5: return 17'd52016;
            6: return 17'd55109;   7: return 17'd58386;   8: return 17'd61858;
            9: return 17'd65536;   10: return 17'd69433;  default: return 17'd73562;
        endcase
    endfunction

    // rebuild the pitch table from the a4 reference
    function automatic void rebuild_pitch_table(input logic [FREQ_W-1:0] a4);
        logic [63:0] p;
        logic [63:0] v;
        for (int n = 0; n < NOTES; n++) begin
            p = 64'(a4) * 64'(ratio_of(n));
            for (int o = 0; o < OCT; o++) begin
                v = (p + (64'd1 << (19 - o))) >> (20 - o);
                pitch_table[n][o] = (v > 64'(FREQ_MAX)) ? FREQ_MAX : v[FREQ_W-1:0];
            end
        end
    endfunction

    // nearest note search and cents computation for one frequency
    function automatic note_result_t find_nearest_note(input logic [FREQ_W-1:0] freq);
        note_result_t r;
        logic [FREQ_W-1:0] x, best, diff, fn, fl, fh, d;
        int bn, bo, lo, ho, sgn;
        longint den, ad, mag, cents;
        logic oor;
        oor = (freq < FREQ_LOW) || (freq > FREQ_HIGH);
        x = oor ? FREQ_SUBST : freq;
        best = '0; bn = 0; bo = 0;
        for (int n = 0; n < NOTES; n++) begin
            for (int o = 0; o < OCT; o++) begin
                diff = (pitch_table[n][o] > x) ? pitch_table[n][o] - x : x - pitch_table[n][o];
                if ((n == 0 && o == 0) || diff < best) begin
                    best = diff; bn = n; bo = o;
                end
            end
        end
        fn = pitch_table[bn][bo];
        r = '0;
        r.note = 4'(bn);
        r.octave = 3'(bo);
        r.out_of_range = oor;
        // lower neighbour, wrapping into the octave below
        fl = '0; r.lower_note = 4'(bn); lo = bo;
        if (bn > 0) begin
            r.lower_note = 4'(bn - 1); r.lower_valid = 1'b1;
        end else if (bo > 0) begin
            r.lower_note = 4'd11; lo = bo - 1; r.lower_valid = 1'b1;
        end
        if (r.lower_valid) fl = pitch_table[r.lower_note][lo];
        // higher neighbour, wrapping into the octave above
        fh = '0; r.higher_note = 4'(bn); ho = bo;
        if (bn < NOTES - 1) begin
            r.higher_note = 4'(bn + 1); r.higher_valid = 1'b1;
        end else if (bo + 1 < OCT) begin
            r.higher_note = 4'd0; ho = bo + 1; r.higher_valid = 1'b1;
        end
        if (r.higher_valid) fh = pitch_table[r.higher_note][ho];
        if (x > fn) begin
            d = x - fn; sgn = 1;
        end else begin
            d = fn - x; sgn = (d != 0) ? -1 : 0;
        end
        cents = 0;
        if (sgn != 0) begin
            den = longint'(sgn > 0 ? fh : fl) - longint'(fn);
            if (den == 0) begin
                cents = 2047;
            end else begin
                ad = (den < 0) ? -den : den;
                mag = (longint'(d) * 3200 + ad) / (2 * ad);
                if (den > 0) cents = (mag > 2047) ? 2047 : mag;
                else cents = (mag > 2048) ? -2048 : -mag;
            end
        end
        r.cents = CENTS_W'(cents);
        r.in_tune = (cents >= -TUNE_LIMIT && cents <= TUNE_LIMIT);
        return r;
    endfunction

    // request driver with bursts and gaps
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_notes.push_back(find_nearest_note(s_measured_freq));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (freq_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_measured_freq <= freq_queue.pop_front();
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge aclk) begin
        note_result_t got, exp_r;
        if (aresetn) begin
            stall_phase <= (stall_phase + 1) % 97;
            m_ready <= (stall_phase < 30) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                got = '{m_nearest_note, m_nearest_octave, m_lower_note, m_lower_valid,
                        m_higher_note, m_higher_valid, m_cents_offset, m_in_tune,
                        m_out_of_range};
                if (expected_notes.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    errors <= errors + 1;
                end else begin
                    exp_r = expected_notes.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch note exp %0d got %0d oct exp %0d got %0d",
                                 $realtime, exp_r.note, got.note, exp_r.octave, got.octave);
                        $display("  lower exp %0d/%0d got %0d/%0d higher exp %0d/%0d got %0d/%0d",
                                 exp_r.lower_note, exp_r.lower_valid, got.lower_note,
                                 got.lower_valid, exp_r.higher_note, exp_r.higher_valid,
                                 got.higher_note, got.higher_valid);
                        $display("  cents exp %0d got %0d tune exp %0d got %0d oor exp %0d got %0d",
                                 $signed(exp_r.cents), $signed(got.cents), exp_r.in_tune,
                                 got.in_tune, exp_r.out_of_range, got.out_of_range);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic drain_requests();
        while (freq_queue.size() > 0 || s_valid || expected_notes.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    task automatic write_reference(input logic [FREQ_W-1:0] a4);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= a4;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rebuild_pitch_table(a4);
    endtask

    // frequency near a table entry, mostly inside the valid window
    function automatic logic [FREQ_W-1:0] random_freq();
        int n, o, off;
        longint f;
        case ($urandom_range(0, 9))
            0: return FREQ_W'($urandom());
            1: return FREQ_W'($urandom_range(0, 2600));
            2: return FREQ_W'($urandom_range(383900, 384100));
            3: return pitch_table[$urandom_range(0, NOTES - 1)][$urandom_range(0, OCT - 1)];
            default: begin
                n = $urandom_range(0, NOTES - 1);
                o = $urandom_range(0, OCT - 1);
                off = $urandom_range(0, 400) - 200;
                f = longint'(pitch_table[n][o]) + off * longint'(pitch_table[n][o]) / 2000;
                if (f < 0) f = 0;
                if (f > longint'(FREQ_MAX)) f = FREQ_MAX;
                return FREQ_W'(f);
            end
        endcase
    endfunction

    task automatic run_phase(input int count);
        for (int i = 0; i < count; i++) freq_queue.push_back(random_freq());
        drain_requests();
    endtask

    initial begin
        logic [FREQ_W-1:0] directed[$];
        rebuild_pitch_table(RESET_A4);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: field extremes, window edges, exact hits, table ends
        directed = '{19'd0, FREQ_MAX, 19'd2559, FREQ_LOW, FREQ_HIGH, 19'd384001,
                     19'h55555, 19'h2AAAA, pitch_table[0][0], pitch_table[11][OCT-1],
                     pitch_table[9][4], pitch_table[0][0] - 19'd5, pitch_table[11][OCT-1] + 19'd40,
                     19'd112650, 19'd112630, pitch_table[0][3] + 19'd1, pitch_table[11][2] - 19'd1};
        foreach (directed[i]) freq_queue.push_back(directed[i]);
        drain_requests();
        run_phase(500);
        // lowest reference: all zero or tiny entries, zero spacing
        write_reference(19'd1);
        freq_queue.push_back(19'd0);
        freq_queue.push_back(FREQ_LOW);
        run_phase(80);
        // highest reference: saturated table
        write_reference(FREQ_MAX);
        freq_queue.push_back(FREQ_MAX);
        freq_queue.push_back(FREQ_HIGH);
        run_phase(150);
        write_reference(19'd108800);
        run_phase(400);
        write_reference(FREQ_W'($urandom_range(20000, 200000)));
        run_phase(250);
        write_reference(RESET_A4);
        run_phase(250);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== nearest_note_cents_finder_core.f =====
hw/rtl/nncf_pkg.sv
hw/rtl/nncf_scan.sv
hw/rtl/nncf_cents.sv
hw/rtl/nearest_note_cents_finder_core.sv
tb/sv/testbench.sv
